/* hdl/irot_pkg.sv */
`default_nettype none

package irot_pkg;

    // Default sizes for the top level parameters
    localparam int DefMaxSide    = 128;
    localparam int DefSampleBits = 16;

    // Register map: index of each register, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_TURN_DIRECTION = 2'd2,
        REG_COLOUR_MODE    = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic [7:0] RstFrameWidth    = 8'd128;
    localparam logic [7:0] RstFrameHeight   = 8'd128;
    localparam logic       RstTurnDirection = 1'b0;
    localparam logic       RstColourMode    = 1'b0;

    // Item command codes
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic {
        STATUS_OK        = 1'b0,
        STATUS_NOT_READY = 1'b1
    } t_status;

    // Turn direction codes
    typedef enum logic {
        DIR_CW  = 1'b0,
        DIR_CCW = 1'b1
    } t_dir;

endpackage

`default_nettype wire

/* hdl/irot_store.sv */
`default_nettype none

module irot_store
    import irot_pkg::*;
#(
    parameter int AddrBits = 14,
    parameter int DataBits = 48
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [AddrBits-1:0] i_wr_addr,
    input  wire logic [DataBits-1:0] i_wr_data,
    input  wire logic                i_rd_en,
    input  wire logic [AddrBits-1:0] i_rd_addr,
    output logic      [DataBits-1:0] o_rd_data
);

    logic [DataBits-1:0] r_mem [2**AddrBits];
    logic [DataBits-1:0] r_rd_data;

    // Write one pixel at its rotated address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one pixel, hold the data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hdl/image_rotate_quarter_turn.sv */
`default_nettype none

// Quarter-turn frame rotator.
// Set frame_width, frame_height, turn_direction and colour_mode over the APB
// port while idle; any register write restarts the frame. Input items carry a
// command: a load item writes the next source pixel (raster order) straight to
// its rotated address in the frame store and gives no result; a fetch item
// reads the next rotated pixel in raster order and gives one result, with
// end_of_frame on the last pixel and status not_ready when the frame is not
// fully loaded or already fully read.
// Throughput: one item per cycle while o_in_stall is low. The store has one
// write port and one registered read port; a load uses the write port, a
// fetch the read port. A fetch result passes through the store read
// register, then the output register. Reset clears the counters and
// restores the register defaults; the frame store contents are undefined
// until loaded. While the receiver stalls, the output holds, one more
// result waits in the read stage, and the input stalls only once both
// are full.
module image_rotate_quarter_turn
    import irot_pkg::*;
#(
    parameter int MAX_SIDE    = DefMaxSide,
    parameter int SAMPLE_BITS = DefSampleBits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [15:0] i_channel_a,
    input  wire logic [15:0] i_channel_b,
    input  wire logic [15:0] i_channel_c,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [15:0] o_out_a,
    output logic      [15:0] o_out_b,
    output logic      [15:0] o_out_c,
    output logic             o_end_of_frame,
    output logic             o_status
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CW = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int SB = SAMPLE_BITS;

    // Clamp a size register to 1..MAX_SIDE
    function automatic logic [SW-1:0] side_of(input logic [7:0] v);
        logic [SW-1:0] s;
        if (v == 8'd0) begin
            s = SW'(1);
        end else if (int'(v) > MAX_SIDE) begin
            s = SW'(MAX_SIDE);
        end else begin
            s = SW'(v);
        end
        return s;
    endfunction

    // Configuration registers
    logic [7:0] r_cfg_width;
    logic [7:0] r_cfg_height;
    t_dir       r_cfg_dir;
    logic       r_cfg_colour;
    logic [7:0] n_cfg_width;
    logic [7:0] n_cfg_height;

    // Frame geometry derived from the registers
    logic [SW-1:0] r_w, r_h, n_w, n_h;
    logic [CW-1:0] r_total;
    logic [AW-1:0] r_ccw_base;

    // Frame counters
    logic [SW-1:0] r_row, r_col;
    logic [CW-1:0] r_loaded, r_read;
    logic [AW-1:0] r_wr_addr, r_row_base;

    // Read stage and output stage
    logic          r_s1_valid, r_s1_ok, r_s1_eof, r_s1_colour;
    logic          r_out_valid;
    logic [15:0]   r_out_a, r_out_b, r_out_c;
    logic          r_out_eof;
    t_status       r_out_status;

    logic          cfg_wr;
    logic          advance, s1_free, accept, is_fetch;
    logic          loaded_full, load_restart, load_take, fetch_ok;
    logic [SW-1:0] eff_row, eff_col, col_inc;
    logic [CW-1:0] eff_loaded;
    logic [AW-1:0] first_base, row_base, wr_addr;
    logic          wrap;
    logic [3*SB-1:0] wr_data, rd_data;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 32'd0;
        case (t_reg_idx'(paddr[3:2]))
            REG_FRAME_WIDTH:    prdata = {24'd0, r_cfg_width};
            REG_FRAME_HEIGHT:   prdata = {24'd0, r_cfg_height};
            REG_TURN_DIRECTION: prdata = {31'd0, r_cfg_dir};
            REG_COLOUR_MODE:    prdata = {31'd0, r_cfg_colour};
            default:            prdata = 32'd0;
        endcase
    end

    // Handshake: the read stage moves on when the output is free
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_free    = !r_s1_valid || advance;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;
    assign is_fetch   = (t_cmd'(i_command) == CMD_FETCH);

    // Size registers as they stand after this cycle's write
    always_comb begin
        n_cfg_width  = r_cfg_width;
        n_cfg_height = r_cfg_height;
        if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_FRAME_WIDTH:  n_cfg_width  = pwdata[7:0];
                REG_FRAME_HEIGHT: n_cfg_height = pwdata[7:0];
                default:          n_cfg_width  = r_cfg_width;
            endcase
        end
    end

    assign n_w = side_of(n_cfg_width);
    assign n_h = side_of(n_cfg_height);

    // Load and fetch decisions, write address stepping
    always_comb begin
        loaded_full  = (r_loaded >= r_total);
        fetch_ok     = loaded_full && (r_read < r_total);
        load_restart = loaded_full && (r_read >= r_total);
        load_take    = accept && !is_fetch && (!loaded_full || load_restart);
        eff_row      = load_restart ? '0 : r_row;
        eff_col      = load_restart ? '0 : r_col;
        eff_loaded   = load_restart ? '0 : r_loaded;
        first_base   = (r_cfg_dir == DIR_CCW) ? r_ccw_base : AW'(r_h - SW'(1));
        row_base     = (eff_row == '0) ? first_base : r_row_base;
        wr_addr      = (eff_col == '0) ? row_base : r_wr_addr;
        col_inc      = eff_col + SW'(1);
        wrap         = (col_inc >= r_w);
        wr_data      = {r_cfg_colour ? i_channel_c[SB-1:0] : SB'(0),
                        r_cfg_colour ? i_channel_b[SB-1:0] : SB'(0),
                        i_channel_a[SB-1:0]};
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RstFrameWidth;
            r_cfg_height <= RstFrameHeight;
            r_cfg_dir    <= t_dir'(RstTurnDirection);
            r_cfg_colour <= RstColourMode;
            r_w          <= side_of(RstFrameWidth);
            r_h          <= side_of(RstFrameHeight);
            r_total      <= CW'(side_of(RstFrameWidth) * side_of(RstFrameHeight));
            r_ccw_base   <= AW'((side_of(RstFrameWidth) - SW'(1))
                                * side_of(RstFrameHeight));
            r_row        <= '0;
            r_col        <= '0;
            r_loaded     <= '0;
            r_read       <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Track geometry of the current registers
            r_w        <= n_w;
            r_h        <= n_h;
            r_total    <= CW'(n_w * n_h);
            r_ccw_base <= AW'((n_w - SW'(1)) * n_h);

            if (cfg_wr) begin
                // Write a register and restart the frame
                case (t_reg_idx'(paddr[3:2]))
                    REG_FRAME_WIDTH:    r_cfg_width  <= pwdata[7:0];
                    REG_FRAME_HEIGHT:   r_cfg_height <= pwdata[7:0];
                    REG_TURN_DIRECTION: r_cfg_dir    <= t_dir'(pwdata[0]);
                    REG_COLOUR_MODE:    r_cfg_colour <= pwdata[0];
                    default:            r_cfg_colour <= r_cfg_colour;
                endcase
                r_row    <= '0;
                r_col    <= '0;
                r_loaded <= '0;
                r_read   <= '0;
            end else begin
                // Advance load position
                if (load_take) begin
                    r_loaded <= eff_loaded + CW'(1);
                    if (load_restart) begin
                        r_read <= '0;
                    end
                    if (wrap) begin
                        r_col <= '0;
                        r_row <= eff_row + SW'(1);
                    end else begin
                        r_col <= col_inc;
                        r_row <= eff_row;
                    end
                end
                // Advance read position
                if (accept && is_fetch && fetch_ok) begin
                    r_read <= r_read + CW'(1);
                end
            end

            // Read stage valid
            if (accept && is_fetch) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end

            // Output valid
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Write address stepping along the rotated frame
    always_ff @(posedge i_clk) begin
        if (load_take) begin
            r_wr_addr <= (r_cfg_dir == DIR_CCW) ? wr_addr - AW'(r_h) : wr_addr + AW'(r_h);
            if (wrap) begin
                r_row_base <= (r_cfg_dir == DIR_CCW) ? row_base + AW'(1)
                                                     : row_base - AW'(1);
            end
        end
    end

    // Capture fetch flags next to the store read
    always_ff @(posedge i_clk) begin
        if (accept && is_fetch) begin
            r_s1_ok     <= fetch_ok;
            r_s1_eof    <= fetch_ok && (r_read == r_total - CW'(1));
            r_s1_colour <= r_cfg_colour;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_a      <= r_s1_ok ? 16'(rd_data[SB-1:0]) : 16'd0;
            r_out_b      <= (r_s1_ok && r_s1_colour) ? 16'(rd_data[2*SB-1:SB]) : 16'd0;
            r_out_c      <= (r_s1_ok && r_s1_colour) ? 16'(rd_data[3*SB-1:2*SB]) : 16'd0;
            r_out_eof    <= r_s1_eof;
            r_out_status <= r_s1_ok ? STATUS_OK : STATUS_NOT_READY;
        end
    end

    irot_store #(
        .AddrBits (AW),
        .DataBits (3 * SB)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load_take),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept && is_fetch),
        .i_rd_addr (r_read[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_out_a        = r_out_a;
    assign o_out_b        = r_out_b;
    assign o_out_c        = r_out_c;
    assign o_end_of_frame = r_out_eof;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire
